### src/hog_pkg.sv
package hog_pkg;

   localparam int CELL_SIZE_DEF      = 16;
   localparam int MAX_CELLS_WIDE_DEF = 8;
   localparam int MAX_CELLS_HIGH_DEF = 8;
   localparam int BIN_COUNT          = 8;

   localparam int KIND_W  = 2;
   localparam int PIXEL_W = 8;
   localparam int ADDR_W  = 9;
   localparam int VALUE_W = 21;
   localparam int CFG_W   = 4;
   localparam int CIDX_W  = 1;
   localparam int GRAD_W  = 9;
   localparam int BIN_W   = 3;
   localparam int RAD_W   = 17;
   localparam int ROOT_W  = 13;
   localparam int WORK_W  = 26;
   localparam int STEP_W  = 4;
   localparam int SQRT_STEPS = 13;

   localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START = 2'd2;

   localparam logic [CIDX_W-1:0] REG_CELLS_WIDE = 1'd0;
   localparam logic [CIDX_W-1:0] REG_CELLS_HIGH = 1'd1;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_FETCH,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_HREAD,
      ST_HWRITE,
      ST_ADVANCE,
      ST_BINRD,
      ST_RESULT
   } state_type;

   function automatic logic [BIN_W-1:0] orient_bin(input logic signed [GRAD_W-1:0] gx,
                                                   input logic signed [GRAD_W-1:0] gy);
      logic signed [GRAD_W:0] x;
      logic signed [GRAD_W:0] y;
      logic [BIN_W-1:0] b;
      x = {gx[GRAD_W-1], gx};
      y = {gy[GRAD_W-1], gy};
      if (x == 0 && y == 0) begin
         b = 3'd0;
      end else if (y >= 0 && x > 0) begin
         b = (y >= x) ? 3'd1 : 3'd0;
      end else if (x <= 0 && y > 0) begin
         b = (-x >= y) ? 3'd3 : 3'd2;
      end else if (y <= 0 && x < 0) begin
         b = (-y >= -x) ? 3'd5 : 3'd4;
      end else begin
         b = (x >= -y) ? 3'd7 : 3'd6;
      end
      return b;
   endfunction

endpackage

### src/hog_cell_histogram.sv
// HOG cell histogram. A command is taken when start is high and busy is low; results
// come out as a one-cycle rsp_valid strobe that cannot be held off, so the receiver
// must take every strobe. Pixel pushes run one at a time through a sequencer around
// two memories: a three-row line buffer and the histogram store. A push walks the
// read, fetch, gradient, square and advance states, adding for each nonzero gradient
// it retires an iterative square root (one magnitude bit per cycle) and a histogram
// read-modify-write; interior rows retire one gradient, the last row up to two. A bin
// read registers its address, reads the store, then strobes rsp_valid. Start and reset
// zero all MAX_CELLS_WIDE*MAX_CELLS_HIGH*8 entries (512 by default) one per cycle
// with busy high. Configuration writes land at once and belong between regions.
module hog_cell_histogram #(
   parameter int CELL_SIZE      = hog_pkg::CELL_SIZE_DEF,
   parameter int MAX_CELLS_WIDE = hog_pkg::MAX_CELLS_WIDE_DEF,
   parameter int MAX_CELLS_HIGH = hog_pkg::MAX_CELLS_HIGH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [hog_pkg::KIND_W-1:0]    req_kind,
   input  logic [hog_pkg::PIXEL_W-1:0]   req_pixel,
   input  logic [hog_pkg::ADDR_W-1:0]    req_bin_address,
   output logic                          rsp_valid,
   output logic [hog_pkg::VALUE_W-1:0]   rsp_bin_value,
   output logic                          rsp_region_done,
   input  logic                          csr_write,
   input  logic [hog_pkg::CIDX_W-1:0]    csr_index,
   input  logic [hog_pkg::CFG_W-1:0]     csr_data
);
   import hog_pkg::*;

   localparam int ROW_LEN    = MAX_CELLS_WIDE * CELL_SIZE;
   localparam int COL_H      = MAX_CELLS_HIGH * CELL_SIZE;
   localparam int LINE_DEPTH = 3 * ROW_LEN;
   localparam int LA_W       = $clog2(LINE_DEPTH);
   localparam int HIST_DEPTH = MAX_CELLS_WIDE * MAX_CELLS_HIGH * BIN_COUNT;
   localparam int HA_W       = $clog2(HIST_DEPTH);
   localparam int IX_W       = HA_W + 4;
   localparam int COL_W      = $clog2(ROW_LEN);
   localparam int W_W        = $clog2(ROW_LEN + 1);
   localparam int H_W        = $clog2(COL_H + 1);
   localparam int CX_W       = $clog2(MAX_CELLS_WIDE + 1);
   localparam int CY_W       = $clog2(MAX_CELLS_HIGH + 1);
   localparam int OFF_W      = $clog2(CELL_SIZE);

   state_type state_ff, state_in;
   logic [HA_W-1:0]    clr_ff, clr_in;
   logic [PIXEL_W-1:0] pix_ff, pix_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [H_W-1:0]     r_ff, r_in;
   logic [COL_W-1:0]   c_ff, c_in;
   logic [1:0]         slot_ff, slot_in;
   logic [CX_W-1:0]    cx_ff, cx_in;
   logic [OFF_W-1:0]   cxo_ff, cxo_in;
   logic [CY_W-1:0]    cy_ff, cy_in;
   logic [OFF_W-1:0]   cyo_ff, cyo_in;
   logic               done_ff, done_in;
   logic [PIXEL_W-1:0] prev1_ff, prev1_in;
   logic [PIXEL_W-1:0] prev2_ff, prev2_in;
   logic [CFG_W-1:0]   cw_ff, cw_in;
   logic [CFG_W-1:0]   ch_ff, ch_in;
   logic [PIXEL_W-1:0] right_ff, right_in;
   logic [PIXEL_W-1:0] left_ff, left_in;
   logic signed [GRAD_W-1:0] gx0_ff, gx0_in;
   logic signed [GRAD_W-1:0] gy0_ff, gy0_in;
   logic signed [GRAD_W-1:0] gx1_ff, gx1_in;
   logic               en0_ff, en0_in;
   logic               en1_ff, en1_in;
   logic               job_ff, job_in;
   logic [HA_W-1:0]    idx_ff, idx_in;
   logic [ROOT_W-1:0]  mag_ff, mag_in;

   logic [CX_W-1:0]    cw_eff;
   logic [CY_W-1:0]    ch_eff;
   logic [W_W-1:0]     w_eff;
   logic [H_W-1:0]     h_eff;
   logic               first_col;
   logic               last_col;
   logic               last_row;
   logic [1:0]         slot_m1;
   logic [1:0]         slot_m2;
   logic [COL_W-1:0]   c_right;
   logic [COL_W-1:0]   c_left;
   logic [W_W-1:0]     c_next;

   logic signed [GRAD_W-1:0] gx_sel;
   logic signed [GRAD_W-1:0] gy_sel;
   logic               en_sel;
   logic [CX_W-1:0]    cx_sel;
   logic [CY_W-1:0]    cy_sel;
   logic signed [2*GRAD_W-1:0] sq_x;
   logic signed [2*GRAD_W-1:0] sq_y;
   logic [2*GRAD_W-1:0] sq_sum;
   logic [IX_W-1:0]    idx_wide;
   logic [VALUE_W:0]   acc_sum;

   logic               lr_we;
   logic [LA_W-1:0]    lr_waddr;
   logic [LA_W-1:0]    lr_raddr_a;
   logic [LA_W-1:0]    lr_raddr_b;
   logic [PIXEL_W-1:0] lr_rdata_a;
   logic [PIXEL_W-1:0] lr_rdata_b;

   logic               hr_we;
   logic [HA_W-1:0]    hr_waddr;
   logic [VALUE_W-1:0] hr_wdata;
   logic [HA_W-1:0]    hr_raddr;
   logic [VALUE_W-1:0] hr_rdata;

   logic               sq_start;
   logic               sq_done;
   logic [ROOT_W-1:0]  sq_root;

   always_comb begin
      // effective region size, out-of-range settings clamp
      if (cw_ff == '0) begin
         cw_eff = CX_W'(1);
      end else if (32'(cw_ff) > MAX_CELLS_WIDE) begin
         cw_eff = CX_W'(MAX_CELLS_WIDE);
      end else begin
         cw_eff = CX_W'(cw_ff);
      end
      if (ch_ff == '0) begin
         ch_eff = CY_W'(1);
      end else if (32'(ch_ff) > MAX_CELLS_HIGH) begin
         ch_eff = CY_W'(MAX_CELLS_HIGH);
      end else begin
         ch_eff = CY_W'(ch_ff);
      end
      w_eff = W_W'(32'(cw_eff) * CELL_SIZE);
      h_eff = H_W'(32'(ch_eff) * CELL_SIZE);

      first_col = (c_ff == '0);
      last_col  = (W_W'(c_ff) == w_eff - W_W'(1));
      last_row  = (r_ff == h_eff - H_W'(1));
      c_next    = W_W'(c_ff) + W_W'(1);
      c_right   = last_col ? c_ff : COL_W'(c_next);
      c_left    = first_col ? c_ff : c_ff - COL_W'(1);

      case (slot_ff)
         2'd0: begin
            slot_m1 = 2'd2;
            slot_m2 = 2'd1;
         end
         2'd1: begin
            slot_m1 = 2'd0;
            slot_m2 = 2'd2;
         end
         default: begin
            slot_m1 = 2'd1;
            slot_m2 = 2'd0;
         end
      endcase

      // gradient of the current job
      if (job_ff) begin
         gx_sel = gx1_ff;
         gy_sel = '0;
         en_sel = en1_ff;
         cx_sel = (cxo_ff == '0) ? cx_ff - CX_W'(1) : cx_ff;
         cy_sel = cy_ff;
      end else begin
         gx_sel = gx0_ff;
         gy_sel = gy0_ff;
         en_sel = en0_ff;
         cx_sel = cx_ff;
         cy_sel = (cyo_ff == '0) ? cy_ff - CY_W'(1) : cy_ff;
      end
      sq_x     = gx_sel * gx_sel;
      sq_y     = gy_sel * gy_sel;
      sq_sum   = 18'(sq_x + sq_y);
      idx_wide = (IX_W'(cy_sel) * IX_W'(cw_eff) + IX_W'(cx_sel)) * IX_W'(BIN_COUNT)
                 + IX_W'(orient_bin(gx_sel, gy_sel));
      acc_sum  = (VALUE_W + 1)'(hr_rdata) + (VALUE_W + 1)'(mag_ff);

      state_in = state_ff;
      clr_in   = clr_ff;
      pix_in   = pix_ff;
      addr_in  = addr_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      slot_in  = slot_ff;
      cx_in    = cx_ff;
      cxo_in   = cxo_ff;
      cy_in    = cy_ff;
      cyo_in   = cyo_ff;
      done_in  = done_ff;
      prev1_in = prev1_ff;
      prev2_in = prev2_ff;
      cw_in    = cw_ff;
      ch_in    = ch_ff;
      right_in = right_ff;
      left_in  = left_ff;
      gx0_in   = gx0_ff;
      gy0_in   = gy0_ff;
      gx1_in   = gx1_ff;
      en0_in   = en0_ff;
      en1_in   = en1_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      mag_in   = mag_ff;

      busy       = (state_ff != ST_IDLE);
      rsp_valid  = 1'b0;
      lr_we      = 1'b0;
      lr_waddr   = LA_W'(32'(slot_ff) * ROW_LEN + 32'(c_ff));
      lr_raddr_a = LA_W'(32'(slot_m1) * ROW_LEN + 32'(c_right));
      lr_raddr_b = LA_W'(32'(slot_m1) * ROW_LEN + 32'(c_left));
      hr_we      = 1'b0;
      hr_waddr   = idx_ff;
      hr_wdata   = acc_sum[VALUE_W] ? VALUE_MAX : acc_sum[VALUE_W-1:0];
      hr_raddr   = (state_ff == ST_BINRD) ? HA_W'(addr_ff) : idx_ff;
      sq_start   = 1'b0;

      if (csr_write) begin
         if (csr_index == REG_CELLS_WIDE) begin
            cw_in = csr_data;
         end else begin
            ch_in = csr_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_PUSH: begin
                     if (!done_ff) begin
                        if (r_ff >= h_eff || W_W'(c_ff) >= w_eff) begin
                           done_in = 1'b1;
                        end else begin
                           pix_in   = req_pixel;
                           state_in = ST_READ;
                        end
                     end
                  end
                  KIND_READ: begin
                     addr_in  = req_bin_address;
                     state_in = ST_BINRD;
                  end
                  KIND_START: begin
                     r_in     = '0;
                     c_in     = '0;
                     slot_in  = '0;
                     cx_in    = '0;
                     cxo_in   = '0;
                     cy_in    = '0;
                     cyo_in   = '0;
                     done_in  = 1'b0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            hr_we    = 1'b1;
            hr_waddr = clr_ff;
            hr_wdata = '0;
            clr_in   = clr_ff + HA_W'(1);
            if (clr_ff == HA_W'(HIST_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            // store the pixel, read neighbors left and right on the row above
            lr_we    = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            right_in   = lr_rdata_a;
            left_in    = lr_rdata_b;
            lr_raddr_a = LA_W'(32'(slot_m2) * ROW_LEN + 32'(c_ff));
            state_in   = ST_GRAD;
         end
         ST_GRAD: begin
            en0_in = (r_ff != '0);
            gx0_in = (!first_col && !last_col)
                     ? GRAD_W'($signed({1'b0, right_ff}) - $signed({1'b0, left_ff})) : '0;
            gy0_in = (r_ff != H_W'(1))
                     ? GRAD_W'($signed({1'b0, pix_ff}) - $signed({1'b0, lr_rdata_a})) : '0;
            en1_in = last_row && !first_col;
            gx1_in = (c_ff != COL_W'(1))
                     ? GRAD_W'($signed({1'b0, pix_ff}) - $signed({1'b0, prev2_ff})) : '0;
            job_in   = 1'b0;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            // zero gradients add nothing
            if (en_sel && (gx_sel != '0 || gy_sel != '0)) begin
               sq_start = 1'b1;
               idx_in   = idx_wide[HA_W-1:0];
               state_in = ST_ROOT;
            end else if (!job_ff) begin
               job_in = 1'b1;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ROOT: begin
            if (sq_done) begin
               mag_in   = sq_root;
               state_in = ST_HREAD;
            end
         end
         ST_HREAD: begin
            state_in = ST_HWRITE;
         end
         ST_HWRITE: begin
            hr_we = 1'b1;
            if (!job_ff) begin
               job_in   = 1'b1;
               state_in = ST_SQUARE;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            prev2_in = prev1_ff;
            prev1_in = pix_ff;
            if (last_row && last_col) begin
               done_in = 1'b1;
            end
            if (c_next >= w_eff) begin
               c_in    = '0;
               cx_in   = '0;
               cxo_in  = '0;
               r_in    = r_ff + H_W'(1);
               slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
               if (cyo_ff == OFF_W'(CELL_SIZE - 1)) begin
                  cyo_in = '0;
                  cy_in  = cy_ff + CY_W'(1);
               end else begin
                  cyo_in = cyo_ff + OFF_W'(1);
               end
            end else begin
               c_in = COL_W'(c_next);
               if (cxo_ff == OFF_W'(CELL_SIZE - 1)) begin
                  cxo_in = '0;
                  cx_in  = cx_ff + CX_W'(1);
               end else begin
                  cxo_in = cxo_ff + OFF_W'(1);
               end
            end
            state_in = ST_IDLE;
         end
         ST_BINRD: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_bin_value   = (32'(addr_ff) < HIST_DEPTH) ? hr_rdata : '0;
      rsp_region_done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         slot_ff  <= '0;
         cx_ff    <= '0;
         cxo_ff   <= '0;
         cy_ff    <= '0;
         cyo_ff   <= '0;
         done_ff  <= 1'b0;
         cw_ff    <= CFG_W'(1);
         ch_ff    <= CFG_W'(1);
         job_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         slot_ff  <= slot_in;
         cx_ff    <= cx_in;
         cxo_ff   <= cxo_in;
         cy_ff    <= cy_in;
         cyo_ff   <= cyo_in;
         done_ff  <= done_in;
         cw_ff    <= cw_in;
         ch_ff    <= ch_in;
         job_ff   <= job_in;
      end
      pix_ff   <= pix_in;
      addr_ff  <= addr_in;
      prev1_ff <= prev1_in;
      prev2_ff <= prev2_in;
      right_ff <= right_in;
      left_ff  <= left_in;
      gx0_ff   <= gx0_in;
      gy0_ff   <= gy0_in;
      gx1_ff   <= gx1_in;
      en0_ff   <= en0_in;
      en1_ff   <= en1_in;
      idx_ff   <= idx_in;
      mag_ff   <= mag_in;
   end

   hog_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .sq_start    (sq_start),
      .sq_radicand (sq_sum[RAD_W-1:0]),
      .sq_done     (sq_done),
      .sq_root     (sq_root)
   );

   hog_line_ram #(
      .DEPTH (LINE_DEPTH),
      .AW    (LA_W)
   ) u_line_ram (
      .clock      (clock),
      .lr_we      (lr_we),
      .lr_waddr   (lr_waddr),
      .lr_wdata   (pix_ff),
      .lr_raddr_a (lr_raddr_a),
      .lr_raddr_b (lr_raddr_b),
      .lr_rdata_a (lr_rdata_a),
      .lr_rdata_b (lr_rdata_b)
   );

   hog_hist_ram #(
      .DEPTH (HIST_DEPTH),
      .AW    (HA_W)
   ) u_hist_ram (
      .clock    (clock),
      .hr_we    (hr_we),
      .hr_waddr (hr_waddr),
      .hr_wdata (hr_wdata),
      .hr_raddr (hr_raddr),
      .hr_rdata (hr_rdata)
   );

endmodule

### src/hog_sqrt.sv
module hog_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        sq_start,
   input  logic [hog_pkg::RAD_W-1:0]   sq_radicand,
   output logic                        sq_done,
   output logic [hog_pkg::ROOT_W-1:0]  sq_root
);
   import hog_pkg::*;

   logic [WORK_W-1:0] v_ff, v_in;
   logic [WORK_W-1:0] n_ff, n_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [WORK_W-1:0] bit_val;
   logic [WORK_W-1:0] trial;

   // one result bit per cycle, remainder kept for rounding
   always_comb begin
      v_in    = v_ff;
      n_in    = n_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      root_in = root_ff;
      bit_val = WORK_W'(1) << {cnt_ff, 1'b0};
      trial   = n_ff + bit_val;
      if (sq_start) begin
         v_in   = WORK_W'(sq_radicand) << 8;
         n_in   = '0;
         cnt_in = STEP_W'(SQRT_STEPS - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            n_in = (n_ff >> 1) + bit_val;
         end else begin
            n_in = n_ff >> 1;
         end
         if (cnt_ff == '0) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - STEP_W'(1);
         end
      end else if (fin_ff) begin
         root_in = ROOT_W'(n_ff) + ROOT_W'(v_ff > n_ff);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      v_ff    <= v_in;
      n_ff    <= n_in;
      cnt_ff  <= cnt_in;
      root_ff <= root_in;
   end

   assign sq_done = done_ff;
   assign sq_root = root_ff;

endmodule

### src/hog_line_ram.sv
module hog_line_ram #(
   parameter int DEPTH = 384,
   parameter int AW    = 9
) (
   input  logic                          clock,
   input  logic                          lr_we,
   input  logic [AW-1:0]                 lr_waddr,
   input  logic [hog_pkg::PIXEL_W-1:0]   lr_wdata,
   input  logic [AW-1:0]                 lr_raddr_a,
   input  logic [AW-1:0]                 lr_raddr_b,
   output logic [hog_pkg::PIXEL_W-1:0]   lr_rdata_a,
   output logic [hog_pkg::PIXEL_W-1:0]   lr_rdata_b
);
   import hog_pkg::*;

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_a_ff;
   logic [PIXEL_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (lr_we) begin
         mem[lr_waddr] <= lr_wdata;
      end
      rd_a_ff <= mem[lr_raddr_a];
      rd_b_ff <= mem[lr_raddr_b];
   end

   assign lr_rdata_a = rd_a_ff;
   assign lr_rdata_b = rd_b_ff;

endmodule

### src/hog_hist_ram.sv
module hog_hist_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                          clock,
   input  logic                          hr_we,
   input  logic [AW-1:0]                 hr_waddr,
   input  logic [hog_pkg::VALUE_W-1:0]   hr_wdata,
   input  logic [AW-1:0]                 hr_raddr,
   output logic [hog_pkg::VALUE_W-1:0]   hr_rdata
);
   import hog_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (hr_we) begin
         mem[hr_waddr] <= hr_wdata;
      end
      rd_ff <= mem[hr_raddr];
   end

   assign hr_rdata = rd_ff;

endmodule

### tb/tb_hog_cell_histogram.sv
module tb_hog_cell_histogram;
   import hog_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int ROW_SPAN = MAX_CELLS_WIDE_DEF * CELL_SIZE_DEF;
   localparam int STORE_DEPTH = MAX_CELLS_WIDE_DEF * MAX_CELLS_HIGH_DEF * BIN_COUNT;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int ITEM_TARGET = 1850;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [PIXEL_W-1:0] pixel;
      logic [ADDR_W-1:0]  addr;
      bit                 fixed;
      logic [VALUE_W-1:0] value;
      logic               done;
   } dir_row_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               done;
   } bin_read_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = KIND_PUSH;
   logic [PIXEL_W-1:0]  req_pixel = '0;
   logic [ADDR_W-1:0]   req_bin_address = '0;
   logic                rsp_valid;
   logic [VALUE_W-1:0]  rsp_bin_value;
   logic                rsp_region_done;
   logic                csr_write = 1'b0;
   logic [CIDX_W-1:0]   csr_index = REG_CELLS_WIDE;
   logic [CFG_W-1:0]    csr_data = '0;

   hog_cell_histogram DUT (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [VALUE_W-1:0] hist [STORE_DEPTH];
   logic [PIXEL_W-1:0] lines [3*ROW_SPAN];
   int unsigned row_pos, col_pos;
   bit region_done;
   logic [CFG_W-1:0] reg_wide, reg_high;

   bin_read_type pending_reads [$];
   int errors = 0;
   int cycles = 0;
   int accepted = 0;
   int idle_pct = 0;

   function automatic int unsigned clamp_cells(logic [CFG_W-1:0] v, int unsigned top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic int unsigned grad_magnitude(int unsigned s);
      int unsigned v, n, t;
      v = s * 256;
      n = 0;
      for (int b = 15; b >= 0; b--) begin
         t = n | (32'd1 << b);
         if (t * t <= v) n = t;
      end
      if (v - n * n > n) n++;
      return n;
   endfunction

   function automatic int unsigned sector(int gx, int gy);
      int ax, ay;
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      if (gx == 0 && gy == 0) return 0;
      if (gy >= 0 && gx > 0) return (ay >= ax) ? 1 : 0;
      if (gx <= 0 && gy > 0) return (ax >= ay) ? 3 : 2;
      if (gy <= 0 && gx < 0) return (ay >= ax) ? 5 : 4;
      return (ax >= ay) ? 7 : 6;
   endfunction

   function automatic int line_px(int unsigned y, int unsigned x);
      return int'(lines[(y % 3) * ROW_SPAN + (x % ROW_SPAN)]);
   endfunction

   function automatic void accumulate(int unsigned y, int unsigned x, int unsigned w,
                                      int unsigned h, int unsigned cw);
      int gx, gy;
      int unsigned idx, sum;
      gx = 0;
      gy = 0;
      if (x != 0 && x != w - 1) gx = line_px(y, x + 1) - line_px(y, x - 1);
      if (y != 0 && y != h - 1) gy = line_px(y + 1, x) - line_px(y - 1, x);
      idx = ((y / CELL_SIZE_DEF) * cw + x / CELL_SIZE_DEF) * BIN_COUNT + sector(gx, gy);
      if (idx >= STORE_DEPTH) return;
      sum = hist[idx] + grad_magnitude(gx * gx + gy * gy);
      hist[idx] = (sum > VALUE_MAX) ? VALUE_MAX : VALUE_W'(sum);
   endfunction

   function automatic bit model_command(logic [KIND_W-1:0] k, logic [PIXEL_W-1:0] p,
                                        logic [ADDR_W-1:0] a, output bin_read_type r);
      int unsigned cw, ch, w, h;
      cw = clamp_cells(reg_wide, MAX_CELLS_WIDE_DEF);
      ch = clamp_cells(reg_high, MAX_CELLS_HIGH_DEF);
      w = cw * CELL_SIZE_DEF;
      h = ch * CELL_SIZE_DEF;
      r.value = '0;
      r.done = region_done;
      case (k)
         KIND_START: begin
            foreach (hist[i]) hist[i] = '0;
            row_pos = 0;
            col_pos = 0;
            region_done = 0;
         end
         KIND_READ: begin
            r.value = (a < STORE_DEPTH) ? hist[a] : '0;
            return 1;
         end
         KIND_PUSH: begin
            if (region_done) return 0;
            if (row_pos >= h || col_pos >= w) begin
               region_done = 1;
               return 0;
            end
            lines[(row_pos % 3) * ROW_SPAN + col_pos] = p;
            if (row_pos >= 1) accumulate(row_pos - 1, col_pos, w, h, cw);
            if (row_pos == h - 1) begin
               if (col_pos >= 1) accumulate(row_pos, col_pos - 1, w, h, cw);
               if (col_pos == w - 1) begin
                  accumulate(row_pos, col_pos, w, h, cw);
                  region_done = 1;
               end
            end
            col_pos++;
            if (col_pos >= w) begin
               col_pos = 0;
               row_pos++;
            end
         end
         default: ;
      endcase
      return 0;
   endfunction

   // called at a falling edge, returns at a falling edge with start still high
   task automatic issue(logic [KIND_W-1:0] k, logic [PIXEL_W-1:0] p, logic [ADDR_W-1:0] a,
                        bit fixed = 0, logic [VALUE_W-1:0] fv = '0, logic fd = 0);
      bin_read_type r;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_kind <= k;
      req_pixel <= p;
      req_bin_address <= a;
      do @(posedge clock); while (busy !== 1'b0);
      accepted++;
      if (model_command(k, p, a, r)) begin
         if (fixed) begin
            r.value = fv;
            r.done = fd;
         end
         pending_reads.push_back(r);
      end
      @(negedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (pending_reads.size() != 0 || busy) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      if (idx == REG_CELLS_WIDE) reg_wide = v;
      else reg_high = v;
   endtask

   task automatic read_some(int n, int unsigned span);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0) issue(KIND_READ, '0, ADDR_W'($urandom_range(511)));
         else issue(KIND_READ, '0, ADDR_W'($urandom_range(span - 1)));
      end
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      bin_read_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_reads.size() == 0) begin
            $display("%0t: unexpected transfer value=%0d done=%0b", $realtime,
                     rsp_bin_value, rsp_region_done);
            errors++;
         end else begin
            e = pending_reads.pop_front();
            if (rsp_bin_value !== e.value) begin
               $display("%0t: bin_value expected %0d actual %0d", $realtime, e.value,
                        rsp_bin_value);
               errors++;
            end
            if (rsp_region_done !== e.done) begin
               $display("%0t: region_done expected %0b actual %0b", $realtime, e.done,
                        rsp_region_done);
               errors++;
            end
         end
      end
   end

   dir_row_type dir_tab [22];

   initial begin
      int plan_w [7];
      int plan_h [7];
      int region, sel, pushes, cw, ch;
      plan_w = '{1, 0, 15, 8, 2, 1, 3};
      plan_h = '{1, 0, 15, 8, 1, 2, 5};
      dir_tab = '{
         '{KIND_READ,   8'd0,   9'd0,   1, 21'd0, 1'b0},
         '{KIND_READ,   8'd0,   9'd511, 1, 21'd0, 1'b0},
         '{KIND_UNUSED, 8'd255, 9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd0,   9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd255, 9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd0,   9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd128, 9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd1,   9'd0,   0, 21'd0, 1'b0},
         '{KIND_READ,   8'd0,   9'd0,   0, 21'd0, 1'b0},
         '{KIND_START,  8'd0,   9'd0,   0, 21'd0, 1'b0},
         '{KIND_READ,   8'd0,   9'd0,   1, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd255, 9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd0,   9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd255, 9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd17,  9'd0,   0, 21'd0, 1'b0},
         '{KIND_PUSH,   8'd200, 9'd0,   0, 21'd0, 1'b0},
         '{KIND_READ,   8'd0,   9'd0,   0, 21'd0, 1'b0},
         '{KIND_READ,   8'd0,   9'd1,   0, 21'd0, 1'b0},
         '{KIND_READ,   8'd0,   9'd7,   0, 21'd0, 1'b0},
         '{KIND_READ,   8'd0,   9'd256, 0, 21'd0, 1'b0},
         '{KIND_UNUSED, 8'd0,   9'd3,   0, 21'd0, 1'b0},
         '{KIND_READ,   8'd0,   9'd511, 1, 21'd0, 1'b0}
      };
      foreach (hist[i]) hist[i] = '0;
      foreach (lines[i]) lines[i] = '0;
      row_pos = 0;
      col_pos = 0;
      region_done = 0;
      reg_wide = 1;
      reg_high = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         issue(dir_tab[i].kind, dir_tab[i].pixel, dir_tab[i].addr, dir_tab[i].fixed,
               dir_tab[i].value, dir_tab[i].done);
      settle();

      region = 0;
      while (accepted < ITEM_TARGET) begin
         idle_pct = (region % 4 == 1) ? 61 : (region % 4 == 3) ? 14 : 0;
         sel = region % 7;
         write_reg(REG_CELLS_WIDE, CFG_W'(plan_w[sel]));
         write_reg(REG_CELLS_HIGH, CFG_W'(plan_h[sel]));
         cw = clamp_cells(reg_wide, MAX_CELLS_WIDE_DEF);
         ch = clamp_cells(reg_high, MAX_CELLS_HIGH_DEF);
         issue(KIND_START, '0, '0);
         if (cw * ch == 1) pushes = 256 + $urandom_range(4);
         else pushes = (sel == 4) ? 20 : $urandom_range(30, 160);
         for (int i = 0; i < pushes; i++) begin
            if ($urandom_range(31) == 0) issue(KIND_UNUSED, pick_pixel(), ADDR_W'($urandom));
            if ($urandom_range(19) == 0) read_some(1, cw * ch * BIN_COUNT);
            issue(KIND_PUSH, pick_pixel(), ADDR_W'($urandom));
         end
         // shrink the width under the current position
         if (sel == 4) begin
            settle();
            write_reg(REG_CELLS_WIDE, CFG_W'(1));
            issue(KIND_PUSH, pick_pixel(), '0);
            issue(KIND_PUSH, pick_pixel(), '0);
         end
         read_some(12, cw * ch * BIN_COUNT);
         if (region % 5 == 2) begin
            issue(KIND_START, '0, '0);
            for (int i = 0; i < 8; i++) issue(KIND_PUSH, pick_pixel(), '0);
            read_some(3, BIN_COUNT);
         end
         settle();
         region++;
      end

      idle_pct = 0;
      settle();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
